// ===== rtl/core/ovbb_pkg.sv =====
// Shared widths, register indexes, beat structs and control/status bundles for the bar builder.
// No dependencies; every other file in rtl/core imports this package.
package ovbb_pkg;

	localparam int StampW     = 32;
	localparam int ProductW   = 8;
	localparam int PriceW     = 32;
	localparam int AmountW    = 32;
	localparam int ValueSumW  = 64;
	localparam int AmountSumW = 48;
	localparam int CfgIndexW  = 2;
	localparam int CfgDataW   = 8;

	localparam logic [CfgIndexW-1:0] CfgProductCode = CfgIndexW'(0);
	localparam logic [CfgIndexW-1:0] CfgOrderSide   = CfgIndexW'(1);

	typedef struct packed {
		logic [StampW-1:0]   stamp;
		logic [ProductW-1:0] item_product;
		logic                item_side;
		logic [PriceW-1:0]   price;
		logic [AmountW-1:0]  amount;
		logic                flush;
	} ovbb_in_t;

	typedef struct packed {
		logic [StampW-1:0] bar_stamp;
		logic [PriceW-1:0] open_price;
		logic [PriceW-1:0] close_price;
		logic [PriceW-1:0] high_price;
		logic [PriceW-1:0] low_price;
		logic              open_undefined;
		logic              close_undefined;
		logic              saturated;
	} ovbb_out_t;

	typedef struct packed {
		logic load_item;
		logic acc;
		logic div_start;
		logic close;
	} ovbb_cmd_t;

	typedef struct packed {
		logic flush;
		logic match;
		logic group_open;
		logic same_stamp;
		logic have_prev;
		logic div_done;
	} ovbb_stat_t;

endpackage

// ===== rtl/core/ovbb_div.sv =====
// Restoring divider, one quotient bit per cycle, for the group average price.
// Depends on ovbb_pkg for the sum widths.
module ovbb_div import ovbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [ValueSumW-1:0]  dividend,
	input  logic [AmountSumW-1:0] divisor,
	output logic                  done,
	output logic [ValueSumW-1:0]  quotient
);

	localparam int CntW = $clog2(ValueSumW);

	logic                  busy_q;
	logic                  done_q;
	logic [CntW-1:0]       cnt_q;
	logic [AmountSumW-1:0] rem_q;
	logic [AmountSumW-1:0] dsr_q;
	logic [ValueSumW-1:0]  quo_q;
	logic [AmountSumW:0]   trial;
	logic [AmountSumW:0]   diff;
	logic                  fits;

	assign trial = {rem_q, quo_q[ValueSumW-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && cnt_q == '0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(ValueSumW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[AmountSumW-1:0] : trial[AmountSumW-1:0];
			quo_q <= {quo_q[ValueSumW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/ovbb_dp.sv =====
// Datapath: item register, configuration, product stage, saturating sums, high/low, bar register.
// Depends on ovbb_pkg and ovbb_div.
module ovbb_dp import ovbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ovbb_in_t             in_data,
	input  logic                 cfg_valid,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	input  ovbb_cmd_t            cmd,
	output ovbb_stat_t           st,
	output ovbb_out_t            out_data
);

	logic [ProductW-1:0]   product_code_q;
	logic                  order_side_q;
	ovbb_in_t              item_q;
	logic [ValueSumW-1:0]  prod_s1;
	logic                  group_open_q;
	logic                  have_prev_q;
	logic [StampW-1:0]     group_stamp_q;
	logic [ValueSumW-1:0]  value_sum_q;
	logic [AmountSumW-1:0] amount_sum_q;
	logic [PriceW-1:0]     high_q;
	logic [PriceW-1:0]     low_q;
	logic                  ovf_q;
	logic [PriceW-1:0]     prev_avg_q;
	logic                  prev_undef_q;
	ovbb_out_t             out_q;
	logic [ValueSumW:0]    vsum;
	logic [AmountSumW:0]   asum;
	logic                  div_done;
	logic [ValueSumW-1:0]  quotient;
	logic                  undef;
	logic [PriceW-1:0]     avg;

	ovbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (value_sum_q),
		.divisor  (amount_sum_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign vsum  = {1'b0, value_sum_q} + {1'b0, prod_s1};
	assign asum  = {1'b0, amount_sum_q} + (AmountSumW+1)'(item_q.amount);
	assign undef = amount_sum_q == '0;
	assign avg   = undef ? '0 :
		(quotient[ValueSumW-1:PriceW] != '0) ? '1 : quotient[PriceW-1:0];

	assign st.flush      = item_q.flush;
	assign st.match      = item_q.item_product == product_code_q &&
		item_q.item_side == order_side_q;
	assign st.group_open = group_open_q;
	assign st.same_stamp = item_q.stamp == group_stamp_q;
	assign st.have_prev  = have_prev_q;
	assign st.div_done   = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			product_code_q <= '0;
			order_side_q   <= 1'b0;
			group_open_q   <= 1'b0;
			have_prev_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CfgProductCode: product_code_q <= cfg_data;
					CfgOrderSide:   order_side_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.acc) begin
				group_open_q <= 1'b1;
			end else if (cmd.close) begin
				group_open_q <= 1'b0;
				have_prev_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ValueSumW'(item_q.price) * ValueSumW'(item_q.amount);
		if (cmd.load_item) begin
			item_q <= in_data;
		end
		if (cmd.acc) begin
			if (!group_open_q) begin
				group_stamp_q <= item_q.stamp;
				value_sum_q   <= prod_s1;
				amount_sum_q  <= AmountSumW'(item_q.amount);
				high_q        <= item_q.price;
				low_q         <= item_q.price;
				ovf_q         <= 1'b0;
			end else begin
				value_sum_q  <= vsum[ValueSumW] ? '1 : vsum[ValueSumW-1:0];
				amount_sum_q <= asum[AmountSumW] ? '1 : asum[AmountSumW-1:0];
				if (vsum[ValueSumW] || asum[AmountSumW]) begin
					ovf_q <= 1'b1;
				end
				if (item_q.price > high_q) begin
					high_q <= item_q.price;
				end
				if (item_q.price < low_q) begin
					low_q <= item_q.price;
				end
			end
		end
		if (cmd.close) begin
			prev_avg_q   <= avg;
			prev_undef_q <= undef;
			if (have_prev_q) begin
				out_q.bar_stamp       <= group_stamp_q;
				out_q.open_price      <= prev_avg_q;
				out_q.close_price     <= avg;
				out_q.high_price      <= high_q;
				out_q.low_price       <= low_q;
				out_q.open_undefined  <= prev_undef_q;
				out_q.close_undefined <= undef;
				out_q.saturated       <= ovf_q;
			end
		end
	end

	assign out_data = out_q;

	a_acc_opens: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc |=> group_open_q)
		else $error("group not open after accumulate");
	a_close_needs_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |-> group_open_q)
		else $error("close without an open group");
	a_close_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close |=> (have_prev_q && !group_open_q))
		else $error("close left group state inconsistent");

endmodule

// ===== rtl/core/ovbb_ctrl.sv =====
// Controller state machine: sequences accept, accumulate, divide and bar hand-off.
// Depends on ovbb_pkg for the command and status bundles.
module ovbb_ctrl import ovbb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  ovbb_stat_t st,
	output ovbb_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_ACC,
		S_DIV,
		S_CLOSE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (st.flush) begin
					if (st.group_open) begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end else begin
						state_d = S_IDLE;
					end
				end else if (!st.match) begin
					state_d = S_IDLE;
				end else if (!st.group_open || st.same_stamp) begin
					state_d = S_ACC;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_IDLE;
			end
			S_DIV: begin
				if (st.div_done) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				if (!st.have_prev || out_free) begin
					cmd.close = 1'b1;
					state_d   = st.flush ? S_IDLE : S_ACC;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.close && st.have_prev) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second beat taken while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.close && st.have_prev) |-> (!out_valid_q || out_ready))
		else $error("bar register overwritten");
	a_div_with_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> st.group_open)
		else $error("divide started without an open group");

endmodule

// ===== rtl/core/ohlc_vwap_bar_builder_core.sv =====
// Top level of the OHLC bar builder with volume-weighted open and close prices.
// Depends on ovbb_pkg, ovbb_ctrl and ovbb_dp (which holds ovbb_div).
//
// The block takes one order beat at a time. A dropped order, or a flush with no open
// group, occupies it only for the item load and the decision; an order that adds to
// the open group or starts the first one passes the item register, the 32x32 product
// stage and the saturating accumulate. An order with a new stamp, or a flush that
// closes a group, runs the restoring divider for the group's average, and the close
// waits while a finished bar is still in the output register. That register holds
// one bar, so the next order is taken while the bar waits. Configuration writes are
// always accepted and take effect at once; write them only while the block is idle.
module ohlc_vwap_bar_builder_core import ovbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ovbb_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ovbb_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	ovbb_cmd_t  cmd;
	ovbb_stat_t st;

	assign cfg_ready = 1'b1;

	ovbb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ovbb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (out_data)
	);

endmodule
